[design/drwt_pkg.sv]
`timescale 1ns / 1ps

package drwt_pkg;

    // clip limit: screen size registers saturate to this many pixels
    localparam int MAX_DIM = 1024;
    localparam logic [11:0] MAX_DIM_W = 12'(MAX_DIM);

    // widths
    localparam int COORD_W   = 11;
    localparam int OFFSET_W  = 10;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 11;
    localparam int ADDR_W    = 16;

    // empty box marker for left and top
    localparam logic [COORD_W-1:0] BOX_EMPTY_LO = 11'd2047;

    // register reset values
    localparam logic [COORD_W-1:0]  SCREEN_WIDTH_RST  = 11'd480;
    localparam logic [COORD_W-1:0]  SCREEN_HEIGHT_RST = 11'd320;
    localparam logic [OFFSET_W-1:0] COLUMN_OFFSET_RST = 10'd0;
    localparam logic [OFFSET_W-1:0] ROW_OFFSET_RST    = 10'd0;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COLUMN_OFFSET = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_OFFSET    = 2'd3;

    // display controller command bytes
    localparam logic [7:0] CMD_SYNC      = 8'hFF;
    localparam logic [7:0] CMD_COL_SET   = 8'h2A;
    localparam logic [7:0] CMD_ROW_SET   = 8'h2B;
    localparam logic [7:0] CMD_MEM_WRITE = 8'h2C;

    typedef enum logic {
        OP_MARK  = 1'b0,
        OP_FLUSH = 1'b1
    } command_t;

    typedef struct packed {
        command_t           command;
        logic signed [15:0] rect_x;
        logic signed [15:0] rect_y;
        logic signed [15:0] rect_w;
        logic signed [15:0] rect_h;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_data;
        logic       last;
    } out_item_t;

endpackage

[design/dirty_region_window_tracker.sv]
`timescale 1ns / 1ps

// Dirty-rectangle tracker for a display controller. Mark items are clipped to
// the screen and widen a stored bounding box; a flush of a non-empty box
// streams twelve bytes (sync, column-set, four column address bytes, row-set,
// four row address bytes, memory-write) and empties the box. An item passes
// through the input register; the box is updated when the item is taken, and
// the sequencer then loads the first flush byte into the output register once
// that register is free. Marks are taken one per cycle, also while a flush is
// streaming, unless a flush waits in the input register. The next flush waits
// there until the previous sequence has been fully loaded into the output
// register. cfg_ready is always high; the user is to write configuration only
// while idle; the block itself does not enforce this.
module dirty_region_window_tracker (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  drwt_pkg::in_item_t                  s_item,
    output logic                                m_valid,
    input  logic                                m_ready,
    output drwt_pkg::out_item_t                 m_item,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [drwt_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [drwt_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import drwt_pkg::*;

    typedef struct packed {
        logic               ok;
        logic [COORD_W-1:0] lo;
        logic [COORD_W-1:0] hi;
    } span_t;

    // byte positions within a flush sequence
    localparam logic [3:0] POS_SYNC    = 4'd0;
    localparam logic [3:0] POS_COL_SET = 4'd1;
    localparam logic [3:0] POS_C0_HI   = 4'd2;
    localparam logic [3:0] POS_C0_LO   = 4'd3;
    localparam logic [3:0] POS_C1_HI   = 4'd4;
    localparam logic [3:0] POS_C1_LO   = 4'd5;
    localparam logic [3:0] POS_ROW_SET = 4'd6;
    localparam logic [3:0] POS_R0_HI   = 4'd7;
    localparam logic [3:0] POS_R0_LO   = 4'd8;
    localparam logic [3:0] POS_R1_HI   = 4'd9;
    localparam logic [3:0] POS_R1_LO   = 4'd10;
    localparam logic [3:0] POS_MEM_WR  = 4'd11;

    // clip [pos, pos+len) to [0, lim)
    function automatic span_t clip_span(logic signed [15:0] pos,
                                        logic signed [15:0] len,
                                        logic [COORD_W-1:0] lim);
        logic signed [17:0] p0;
        logic signed [17:0] e;
        logic signed [17:0] l;
        logic signed [17:0] hi;
        span_t              r;
        p0   = (pos < 0) ? 18'sd0 : 18'(pos);
        e    = 18'(pos) + 18'(len);
        l    = $signed({7'b0, lim});
        hi   = (e > l) ? l : e;
        r.ok = (hi > p0);
        r.lo = p0[COORD_W-1:0];
        r.hi = hi[COORD_W-1:0];
        return r;
    endfunction

    // saturate a screen size register to the clip limit
    function automatic logic [COORD_W-1:0] clip_dim(logic [COORD_W-1:0] reg_val);
        return ({1'b0, reg_val} > MAX_DIM_W) ? MAX_DIM_W[COORD_W-1:0] : reg_val;
    endfunction

    // configuration registers
    logic [COORD_W-1:0]  screen_width_reg,  screen_width_next;
    logic [COORD_W-1:0]  screen_height_reg, screen_height_next;
    logic [OFFSET_W-1:0] column_offset_reg, column_offset_next;
    logic [OFFSET_W-1:0] row_offset_reg,    row_offset_next;

    // input register
    logic     in_valid_reg, in_valid_next;
    in_item_t in_reg,       in_next;

    // dirty box
    logic [COORD_W-1:0] box_left_reg,   box_left_next;
    logic [COORD_W-1:0] box_right_reg,  box_right_next;
    logic [COORD_W-1:0] box_top_reg,    box_top_next;
    logic [COORD_W-1:0] box_bottom_reg, box_bottom_next;

    // byte sequencer
    logic              seq_active_reg, seq_active_next;
    logic [3:0]        seq_pos_reg,    seq_pos_next;
    logic [ADDR_W-1:0] col_first_reg,  col_first_next;
    logic [ADDR_W-1:0] col_last_reg,   col_last_next;
    logic [ADDR_W-1:0] row_first_reg,  row_first_next;
    logic [ADDR_W-1:0] row_last_reg,   row_last_next;

    // output register
    logic      m_valid_reg, m_valid_next;
    out_item_t m_item_reg,  m_item_next;

    logic      in_take;
    logic      out_free;
    logic      box_full;
    span_t     span_x;
    span_t     span_y;
    out_item_t seq_byte;

    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_item    = m_item_reg;

    // a flush waits while the sequencer still streams the previous window
    assign in_take  = in_valid_reg && ((in_reg.command == OP_MARK) || !seq_active_reg);
    assign s_ready  = !in_valid_reg || in_take;
    assign out_free = !m_valid_reg || m_ready;
    assign box_full = (box_left_reg < box_right_reg) && (box_top_reg < box_bottom_reg);

    assign span_x = clip_span(in_reg.rect_x, in_reg.rect_w, clip_dim(screen_width_reg));
    assign span_y = clip_span(in_reg.rect_y, in_reg.rect_h, clip_dim(screen_height_reg));

    // configuration writes
    always_comb begin
        screen_width_next  = screen_width_reg;
        screen_height_next = screen_height_reg;
        column_offset_next = column_offset_reg;
        row_offset_next    = row_offset_reg;
        if (cfg_valid) begin
            case (cfg_index)
                REG_SCREEN_WIDTH:  screen_width_next  = cfg_data;
                REG_SCREEN_HEIGHT: screen_height_next = cfg_data;
                REG_COLUMN_OFFSET: column_offset_next = cfg_data[OFFSET_W-1:0];
                REG_ROW_OFFSET:    row_offset_next    = cfg_data[OFFSET_W-1:0];
                default: ;
            endcase
        end
    end

    // byte selection for the current sequencer position
    always_comb begin
        seq_byte = '{out_byte: 8'h00, is_data: 1'b1, last: 1'b0};
        case (seq_pos_reg)
            POS_SYNC:    seq_byte = '{out_byte: CMD_SYNC,    is_data: 1'b0, last: 1'b0};
            POS_COL_SET: seq_byte = '{out_byte: CMD_COL_SET, is_data: 1'b0, last: 1'b0};
            POS_C0_HI:   seq_byte.out_byte = col_first_reg[15:8];
            POS_C0_LO:   seq_byte.out_byte = col_first_reg[7:0];
            POS_C1_HI:   seq_byte.out_byte = col_last_reg[15:8];
            POS_C1_LO:   seq_byte.out_byte = col_last_reg[7:0];
            POS_ROW_SET: seq_byte = '{out_byte: CMD_ROW_SET, is_data: 1'b0, last: 1'b0};
            POS_R0_HI:   seq_byte.out_byte = row_first_reg[15:8];
            POS_R0_LO:   seq_byte.out_byte = row_first_reg[7:0];
            POS_R1_HI:   seq_byte.out_byte = row_last_reg[15:8];
            POS_R1_LO:   seq_byte.out_byte = row_last_reg[7:0];
            POS_MEM_WR:  seq_byte = '{out_byte: CMD_MEM_WRITE, is_data: 1'b0, last: 1'b1};
            default:     seq_byte = '{out_byte: 8'h00, is_data: 1'b0, last: 1'b0};
        endcase
    end

    // input register, box update, sequencer and output register
    always_comb begin
        in_valid_next   = in_valid_reg;
        in_next         = in_reg;
        box_left_next   = box_left_reg;
        box_right_next  = box_right_reg;
        box_top_next    = box_top_reg;
        box_bottom_next = box_bottom_reg;
        seq_active_next = seq_active_reg;
        seq_pos_next    = seq_pos_reg;
        col_first_next  = col_first_reg;
        col_last_next   = col_last_reg;
        row_first_next  = row_first_reg;
        row_last_next   = row_last_reg;
        m_valid_next    = m_valid_reg;
        m_item_next     = m_item_reg;

        // input transfer
        if (s_ready) begin
            in_valid_next = s_valid;
            in_next       = s_item;
        end

        // sequencer feeds the output register one byte per free cycle
        if (out_free) begin
            m_valid_next = seq_active_reg;
            if (seq_active_reg) begin
                m_item_next  = seq_byte;
                seq_pos_next = seq_pos_reg + 4'd1;
                if (seq_pos_reg == POS_MEM_WR) begin
                    seq_active_next = 1'b0;
                end
            end
        end

        // consume the registered item
        if (in_take) begin
            if (in_reg.command == OP_MARK) begin
                if (span_x.ok && span_y.ok) begin
                    if (span_x.lo < box_left_reg)   box_left_next   = span_x.lo;
                    if (span_x.hi > box_right_reg)  box_right_next  = span_x.hi;
                    if (span_y.lo < box_top_reg)    box_top_next    = span_y.lo;
                    if (span_y.hi > box_bottom_reg) box_bottom_next = span_y.hi;
                end
            end else if (box_full) begin
                // snapshot the window and empty the box
                col_first_next  = ADDR_W'(box_left_reg) + ADDR_W'(column_offset_reg);
                col_last_next   = ADDR_W'(box_right_reg) - 16'd1 + ADDR_W'(column_offset_reg);
                row_first_next  = ADDR_W'(box_top_reg) + ADDR_W'(row_offset_reg);
                row_last_next   = ADDR_W'(box_bottom_reg) - 16'd1 + ADDR_W'(row_offset_reg);
                seq_active_next = 1'b1;
                seq_pos_next    = POS_SYNC;
                box_left_next   = BOX_EMPTY_LO;
                box_right_next  = '0;
                box_top_next    = BOX_EMPTY_LO;
                box_bottom_next = '0;
            end
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            screen_width_reg  <= SCREEN_WIDTH_RST;
            screen_height_reg <= SCREEN_HEIGHT_RST;
            column_offset_reg <= COLUMN_OFFSET_RST;
            row_offset_reg    <= ROW_OFFSET_RST;
            in_valid_reg      <= 1'b0;
            box_left_reg      <= BOX_EMPTY_LO;
            box_right_reg     <= '0;
            box_top_reg       <= BOX_EMPTY_LO;
            box_bottom_reg    <= '0;
            seq_active_reg    <= 1'b0;
            seq_pos_reg       <= POS_SYNC;
            m_valid_reg       <= 1'b0;
        end else begin
            screen_width_reg  <= screen_width_next;
            screen_height_reg <= screen_height_next;
            column_offset_reg <= column_offset_next;
            row_offset_reg    <= row_offset_next;
            in_valid_reg      <= in_valid_next;
            box_left_reg      <= box_left_next;
            box_right_reg     <= box_right_next;
            box_top_reg       <= box_top_next;
            box_bottom_reg    <= box_bottom_next;
            seq_active_reg    <= seq_active_next;
            seq_pos_reg       <= seq_pos_next;
            m_valid_reg       <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        in_reg        <= in_next;
        col_first_reg <= col_first_next;
        col_last_reg  <= col_last_next;
        row_first_reg <= row_first_next;
        row_last_reg  <= row_last_next;
        m_item_reg    <= m_item_next;
    end

endmodule

[design/drwt_checker.sv]
`timescale 1ns / 1ps

module drwt_checker (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    input  logic                                s_ready,
    input  drwt_pkg::in_item_t                  s_item,
    input  logic                                m_valid,
    input  logic                                m_ready,
    input  drwt_pkg::out_item_t                 m_item
);
    import drwt_pkg::*;

    // stalled input holds
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_item))
        else $error("input changed while stalled");

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("result changed while stalled");

    // the closing byte is always the memory-write command
    a_last_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.last |-> m_item.out_byte == CMD_MEM_WRITE && !m_item.is_data)
        else $error("last flag on a byte other than memory-write");

    // a window sequence streams without gaps once started
    a_no_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_item.last |=> m_valid)
        else $error("gap inside a flush sequence");

    // nothing is presented right after reset
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind dirty_region_window_tracker drwt_checker u_drwt_checker (.*);
